[src/humidity_temp_frame_checker_core_macros.svh]
// Assertion macros used by the frame checker RTL.
`ifndef HUMIDITY_TEMP_FRAME_CHECKER_CORE_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_CHECKER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HTFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/htfc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package htfc_pkg;

  // CRC-8 as used by the sensor: polynomial 0x31, seed 0xFF, no reflection.
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Scale factors of the conversions, in hundredths.
  localparam logic [15:0] TEMP_SPAN  = 16'd17500;
  localparam logic [15:0] RH_SPAN    = 16'd10000;
  localparam logic [15:0] FULL_SCALE = 16'd65535;
  localparam logic [15:0] F_MUL      = 16'd9;
  localparam logic [15:0] F_DIV      = 16'd5;
  localparam logic [14:0] TC_OFFSET  = 15'd4500;
  // 4900 = 8100 - 3200, the offset left after floor(9 * q / 5).
  localparam logic [15:0] TF_OFFSET  = 16'd4900;

  // Byte positions inside a frame.
  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  // Last step indices of the serial multiply/divide unit.
  localparam logic [4:0] MUL_LAST = 5'd15;
  localparam logic [4:0] DIV_LAST = 5'd31;

  typedef struct packed {
    logic       start;
    logic       seed_init;
    logic       clear;
    logic [7:0] data;
  } crc_ctl_t;

  typedef struct packed {
    logic        start;
    logic [15:0] mul;
    logic [15:0] div;
    logic [15:0] x;
  } md_ctl_t;

endpackage

`default_nettype wire

[src/htfc_crc8.sv]
`timescale 1ns / 1ps
`default_nettype none

module htfc_crc8 (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire htfc_pkg::crc_ctl_t ctl,
  output logic [7:0]             crc,
  output logic                   busy
);

  logic [7:0] c_r;
  logic [2:0] cnt_r;
  logic       busy_r;

  // One polynomial step per cycle while busy and no clear or start arrives, eight steps per byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r    <= htfc_pkg::CRC_INIT;
      cnt_r  <= 3'd0;
      busy_r <= 1'b0;
    end else if (ctl.clear) begin
      c_r <= htfc_pkg::CRC_INIT;
    end else if (ctl.start) begin
      c_r    <= (ctl.seed_init ? htfc_pkg::CRC_INIT : c_r) ^ ctl.data;
      cnt_r  <= 3'd0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      c_r   <= c_r[7] ? ({c_r[6:0], 1'b0} ^ htfc_pkg::CRC_POLY) : {c_r[6:0], 1'b0};
      cnt_r <= cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign crc  = c_r;
  assign busy = busy_r;

endmodule

`default_nettype wire

[src/htfc_muldiv.sv]
`timescale 1ns / 1ps
`default_nettype none

// Computes floor(mul * x / div) bit-serially: 16 shift-add steps, then
// 32 restoring division steps that shift the quotient into the product word.
module htfc_muldiv (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire htfc_pkg::md_ctl_t ctl,
  output logic [15:0]           quo,
  output logic                  done
);

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_t;

  md_state_t   st_r;
  logic [4:0]  cnt_r;
  logic        done_r;
  logic [31:0] p_r;
  logic [15:0] x_r;
  logic [15:0] m_r;
  logic [15:0] d_r;
  logic [15:0] r_r;

  logic [16:0] rs;
  logic [16:0] diff;
  logic        ge;

  always_comb begin
    rs   = {r_r, p_r[31]};
    diff = rs - {1'b0, d_r};
    ge   = (rs >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= MD_IDLE;
      cnt_r  <= 5'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        MD_IDLE: begin
          if (ctl.start) begin
            m_r   <= ctl.mul;
            d_r   <= ctl.div;
            x_r   <= ctl.x;
            p_r   <= 32'd0;
            cnt_r <= 5'd0;
            st_r  <= MD_MUL;
          end
        end
        MD_MUL: begin
          p_r   <= {p_r[30:0], 1'b0} + (x_r[15] ? {16'd0, m_r} : 32'd0);
          x_r   <= {x_r[14:0], 1'b0};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == htfc_pkg::MUL_LAST) begin
            cnt_r <= 5'd0;
            r_r   <= 16'd0;
            st_r  <= MD_DIV;
          end
        end
        MD_DIV: begin
          // The remainder stays below the divisor, so 16 bits hold it.
          r_r   <= ge ? diff[15:0] : rs[15:0];
          p_r   <= {p_r[30:0], ge};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == htfc_pkg::DIV_LAST) begin
            done_r <= 1'b1;
            st_r   <= MD_IDLE;
          end
        end
        default: begin
          st_r <= MD_IDLE;
        end
      endcase
    end
  end

  assign quo  = p_r[15:0];
  assign done = done_r;

endmodule

`default_nettype wire

[src/humidity_temp_frame_checker_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | tdata (low bit up)                          | tuser
// in_      | slave     | rx_byte                                     | frame_start
// out_     | master    | temp_raw, hum_raw, temp_centi_c,            | status
//          |           | temp_centi_f, hum_centi_rh, 3 zero bits     |
//
// A word byte goes through the transfer, eight CRC-8 bit steps and the return to ready.
// A CRC byte of the temperature word is checked while the core stays ready.
// The last byte of a frame runs three 48-step passes of the shared
// multiply/divide unit, a handoff after each, and the result load.
// Reset (rst_n, synchronous, active low) starts a fresh frame with no result.
// A waiting result does not stop input; only the next result's load waits on out_tready.
`include "humidity_temp_frame_checker_core_macros.svh"

module humidity_temp_frame_checker_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic        in_tuser,   // [0] frame_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [15:0] temp_raw, [31:16] hum_raw, [46:32] temp_centi_c,
  // [62:47] temp_centi_f, [76:63] hum_centi_rh, [79:77] zero
  output logic [79:0]      out_tdata,
  output logic             out_tuser   // [0] status
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CRC    = 6'b000010,
    ST_CONV_T = 6'b000100,
    ST_CONV_F = 6'b001000,
    ST_CONV_H = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t      state_r;
  state_t      state_nxt;
  logic [2:0]  pos_r;
  logic [2:0]  pos_eff;
  logic        crc_failed_r;
  logic [15:0] temp_word_r;
  logic [15:0] hum_word_r;
  logic [14:0] q_t_r;
  logic [14:0] q_f_r;
  logic [13:0] rh_r;
  logic        out_tvalid_r;
  logic [79:0] out_tdata_r;
  logic        out_tuser_r;

  logic                accept;
  logic                mismatch;
  logic                emit_load;
  htfc_pkg::crc_ctl_t  crc_ctl;
  htfc_pkg::md_ctl_t   md_ctl;
  logic [7:0]          crc_val;
  logic                crc_busy;
  logic [15:0]         md_quo;
  logic                md_done;
  logic [14:0]         temp_c;
  logic [15:0]         temp_f;

  htfc_crc8 u_crc (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (crc_ctl),
    .crc  (crc_val),
    .busy (crc_busy)
  );

  htfc_muldiv u_muldiv (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (md_ctl),
    .quo  (md_quo),
    .done (md_done)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign mismatch  = (crc_val != in_tdata);
  assign emit_load = (state_r == ST_EMIT) && (!out_tvalid_r || out_tready);

  // A frame start, or a position code past the last byte, restarts the frame.
  assign pos_eff = (in_tuser || (pos_r > htfc_pkg::POS_H_CRC)) ? htfc_pkg::POS_T_MSB : pos_r;

  assign temp_c = q_t_r - htfc_pkg::TC_OFFSET;
  assign temp_f = {1'b0, q_f_r} - htfc_pkg::TF_OFFSET;

  always_comb begin
    state_nxt         = state_r;
    crc_ctl           = '0;
    crc_ctl.data      = in_tdata;
    md_ctl            = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (pos_eff) inside
            htfc_pkg::POS_T_MSB, htfc_pkg::POS_H_MSB: begin
              crc_ctl.start     = 1'b1;
              crc_ctl.seed_init = 1'b1;
              state_nxt         = ST_CRC;
            end
            htfc_pkg::POS_T_LSB, htfc_pkg::POS_H_LSB: begin
              crc_ctl.start = 1'b1;
              state_nxt     = ST_CRC;
            end
            htfc_pkg::POS_T_CRC: begin
              crc_ctl.clear = 1'b1;
            end
            htfc_pkg::POS_H_CRC: begin
              crc_ctl.clear = 1'b1;
              md_ctl.start  = 1'b1;
              md_ctl.mul    = htfc_pkg::TEMP_SPAN;
              md_ctl.div    = htfc_pkg::FULL_SCALE;
              md_ctl.x      = temp_word_r;
              state_nxt     = ST_CONV_T;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CRC: begin
        if (!crc_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CONV_T: begin
        // Fahrenheit reduces to floor(9 * q / 5) minus a fixed offset.
        if (md_done) begin
          md_ctl.start = 1'b1;
          md_ctl.mul   = htfc_pkg::F_MUL;
          md_ctl.div   = htfc_pkg::F_DIV;
          md_ctl.x     = md_quo;
          state_nxt    = ST_CONV_F;
        end
      end
      ST_CONV_F: begin
        if (md_done) begin
          md_ctl.start = 1'b1;
          md_ctl.mul   = htfc_pkg::RH_SPAN;
          md_ctl.div   = htfc_pkg::FULL_SCALE;
          md_ctl.x     = hum_word_r;
          state_nxt    = ST_CONV_H;
        end
      end
      ST_CONV_H: begin
        if (md_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_r        <= htfc_pkg::POS_T_MSB;
      crc_failed_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (accept) begin
        pos_r <= (pos_eff == htfc_pkg::POS_H_CRC) ? htfc_pkg::POS_T_MSB : pos_eff + 3'd1;
        case (pos_eff) inside
          htfc_pkg::POS_T_MSB: begin
            temp_word_r  <= {in_tdata, 8'h00};
            crc_failed_r <= 1'b0;
          end
          htfc_pkg::POS_T_LSB: begin
            temp_word_r[7:0] <= in_tdata;
          end
          htfc_pkg::POS_H_MSB: begin
            hum_word_r <= {in_tdata, 8'h00};
          end
          htfc_pkg::POS_H_LSB: begin
            hum_word_r[7:0] <= in_tdata;
          end
          htfc_pkg::POS_T_CRC, htfc_pkg::POS_H_CRC: begin
            if (mismatch) begin
              crc_failed_r <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      if (md_done) begin
        case (state_r)
          ST_CONV_T: q_t_r <= md_quo[14:0];
          ST_CONV_F: q_f_r <= md_quo[14:0];
          ST_CONV_H: rh_r  <= md_quo[13:0];
          default: begin
          end
        endcase
      end

      if (emit_load) begin
        out_tvalid_r <= 1'b1;
        out_tuser_r  <= crc_failed_r;
        out_tdata_r  <= {3'b000, rh_r, temp_f, temp_c, hum_word_r, temp_word_r};
        crc_failed_r <= 1'b0;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `HTFC_ASSERT_NOW(a_crc_busy_blocks_input, clk, rst_n, crc_busy, !in_tready,
                   "input taken while the CRC unit is still stepping")
  `HTFC_ASSERT_NOW(a_conv_done_in_conv, clk, rst_n, md_done,
                   (state_r == ST_CONV_T) || (state_r == ST_CONV_F) || (state_r == ST_CONV_H),
                   "conversion finished outside a conversion state")
  `HTFC_ASSERT_NEXT(a_last_byte_wraps, clk, rst_n,
                    accept && (pos_eff == htfc_pkg::POS_H_CRC),
                    (pos_r == htfc_pkg::POS_T_MSB) && (state_r == ST_CONV_T),
                    "last frame byte did not start conversion and rewind the count")

endmodule

`default_nettype wire
